### sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define FPE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition that must never be seen outside reset
`define FPE_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define FPE_ASSERT(label, clk, rst_n, prop)
`define FPE_NEVER(label, clk, rst_n, cond)
`endif
`endif

### sv/fpe_pkg.sv
// shared types, character codes and helper functions of the filename escaper
package fpe_pkg;

    // job queue geometry
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    // configuration register map
    localparam logic        REG_IDX_OUT_CAPACITY = 1'b0;
    localparam logic [15:0] CAP_RESET            = 16'd256;

    // hold counter codes
    localparam logic [2:0] HELD_NONE  = 3'd0;
    localparam logic [2:0] HELD_COMMA = 3'd1;
    localparam logic [2:0] HELD_FULL  = 3'd4;

    // character codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_NBSP   = 8'hA0;
    localparam logic [7:0] CHAR_PCT    = 8'h25;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_PIPE   = 8'h7C;
    localparam logic [7:0] CHAR_QMARK  = 8'h3F;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;

    // what a unit of output work is
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_ESC,
        TAIL_TERM
    } tail_kind_t;

    // one classified input byte together with the hold it releases
    typedef struct packed {
        logic [2:0]      flush_cnt;
        logic            esc_comma;
        logic [2:0][7:0] digits;
        tail_kind_t      tail_kind;
        logic [7:0]      tail_byte;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic needs_escape(input logic [7:0] c);
        return (c == CHAR_PCT)   || (c == CHAR_LT)    || (c == CHAR_GT)    ||
               (c == CHAR_COLON) || (c == CHAR_QUOTE) || (c == CHAR_PIPE)  ||
               (c == CHAR_QMARK) || (c == CHAR_STAR)  || (c == CHAR_BSLASH) ||
               (c < CTRL_LIMIT)  || (c == CHAR_DEL);
    endfunction

    // uppercase hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + {4'h0, nib};
        end
        return 8'h37 + {4'h0, nib};
    endfunction

endpackage

### sv/filename_percent_escape_encoder.sv
// top level of the streaming filename escaper
// The block takes one name byte per beat and can accept a byte every cycle while its
// four-entry job queue has room. A plain or mapped byte leaves as one beat, a percent
// escape as three; a released comma hold leaves one beat per held byte, but a comma
// held with three digits at the terminator is escaped. The back part, writing one beat
// per cycle into the output register when not stalled, sets the sustained rate. Hex
// digits that follow a comma are held and produce no beat until a later byte or the
// terminator settles them. Each name ends with a tlast beat whose tuser bit reports
// that the output did not fit in out_capacity bytes. There is no clearing pass after
// reset; out_capacity resets to 256 and should be written only while the block is idle.
`include "assert_macros.svh"

module filename_percent_escape_encoder
    import fpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // [0] overflow_error
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] cap_reg;
    logic        cfg_write;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        head_job;
    q_status_t   q_stat;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_IDX_OUT_CAPACITY);
    assign prdata    = (paddr[2] == REG_IDX_OUT_CAPACITY) ? {16'd0, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    // byte classification and comma hold
    fpe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // job queue
    fpe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // output sequencer
    fpe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .capacity  (cap_reg),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_err   (m_axis_tuser)
    );

    // checks
    `FPE_ASSERT(a_err_only_on_last, clk, rst_n, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    `FPE_NEVER(a_queue_full_and_empty, clk, rst_n, q_stat.full && q_stat.empty)
    `FPE_ASSERT(a_beat_from_job, clk, rst_n, $rose(m_axis_tvalid) |-> $past(!q_stat.empty))

endmodule

### sv/fpe_front.sv
// front part: accepts name bytes, tracks the comma hold and builds jobs
module fpe_front
    import fpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  q_status_t  q_stat,
    output logic       push,
    output job_t       push_job
);

    logic [2:0]      held_count_reg;
    logic [2:0]      held_count_next;
    logic [2:0][7:0] digits_reg;
    logic [2:0][7:0] digits_next;
    logic            accept;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // classify the byte and decide what the hold does
    always_comb
    begin
        held_count_next    = held_count_reg;
        digits_next        = digits_reg;
        push               = 1'b0;
        push_job.flush_cnt = held_count_reg;
        push_job.esc_comma = 1'b0;
        push_job.digits    = digits_reg;
        push_job.tail_kind = TAIL_NONE;
        push_job.tail_byte = in_char;
        if (accept)
        begin
            if (in_char == CHAR_NUL)
            begin
                push_job.esc_comma = (held_count_reg == HELD_FULL);
                push_job.tail_kind = TAIL_TERM;
                push               = 1'b1;
                held_count_next    = HELD_NONE;
            end
            else if ((held_count_reg != HELD_NONE) && (held_count_reg != HELD_FULL) &&
                     is_hex(in_char))
            begin
                digits_next[held_count_reg[1:0] - 2'd1] = in_char;
                held_count_next = held_count_reg + 3'd1;
            end
            else if (in_char == CHAR_COMMA)
            begin
                push            = (held_count_reg != HELD_NONE);
                held_count_next = HELD_COMMA;
            end
            else
            begin
                push            = 1'b1;
                held_count_next = HELD_NONE;
                if (in_char == CHAR_SLASH)
                begin
                    push_job.tail_kind = TAIL_BYTE;
                    push_job.tail_byte = CHAR_DOT;
                end
                else if (in_char == CHAR_SPACE)
                begin
                    push_job.tail_kind = TAIL_BYTE;
                    push_job.tail_byte = CHAR_NBSP;
                end
                else if (needs_escape(in_char))
                begin
                    push_job.tail_kind = TAIL_ESC;
                end
                else
                begin
                    push_job.tail_kind = TAIL_BYTE;
                end
            end
        end
    end

    // hold counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
        end
        else
        begin
            held_count_reg <= held_count_next;
        end
    end

    // held digits
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
    end

endmodule

### sv/fpe_queue.sv
// short job queue between the front and back parts
module fpe_queue
    import fpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t q_stat
);

    job_t             mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;
    logic [QCntW-1:0] count_next;

    assign head_job     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCntW'(QDepth));
    assign q_stat.empty = (count_reg == '0);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/fpe_back.sv
// back part: walks the units of each job, checks capacity and emits beats
module fpe_back
    import fpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head_job,
    input  q_status_t   q_stat,
    input  logic [15:0] capacity,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_err
);

    logic [2:0]  unit_reg;
    logic [2:0]  unit_next;
    logic [1:0]  sub_reg;
    logic [1:0]  sub_next;
    logic [15:0] bw_reg;
    logic [15:0] bw_next;
    logic        failed_reg;
    logic        failed_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        out_err_reg;
    logic        out_err_next;

    tail_kind_t  kind;
    logic [7:0]  unit_byte;
    logic [1:0]  unit_len;
    logic        last_unit;
    logic        fits;
    logic        go;
    logic        done_unit;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

    // select the current unit of the head job
    always_comb
    begin
        if (unit_reg < head_job.flush_cnt)
        begin
            if (unit_reg == 3'd0)
            begin
                kind      = head_job.esc_comma ? TAIL_ESC : TAIL_BYTE;
                unit_byte = CHAR_COMMA;
            end
            else
            begin
                kind      = TAIL_BYTE;
                unit_byte = head_job.digits[unit_reg[1:0] - 2'd1];
            end
        end
        else
        begin
            kind      = head_job.tail_kind;
            unit_byte = head_job.tail_byte;
        end
        last_unit = (unit_reg >= head_job.flush_cnt) ||
                    ((head_job.tail_kind == TAIL_NONE) &&
                     (unit_reg == (head_job.flush_cnt - 3'd1)));
        unit_len  = (kind == TAIL_ESC) ? 2'd3 : 2'd1;
        fits      = !failed_reg &&
                    (({1'b0, bw_reg} + {15'd0, unit_len}) < {1'b0, capacity});
    end

    // unit sequencer and capacity accounting
    always_comb
    begin
        go             = !q_stat.empty && (!out_valid_reg || out_ready);
        done_unit      = 1'b0;
        pop            = 1'b0;
        unit_next      = unit_reg;
        sub_next       = sub_reg;
        bw_next        = bw_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (go)
        begin
            case (kind)
                TAIL_TERM:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CHAR_NUL;
                    out_last_next  = 1'b1;
                    out_err_next   = failed_reg || (bw_reg >= capacity);
                    bw_next        = '0;
                    failed_next    = 1'b0;
                    done_unit      = 1'b1;
                end
                TAIL_ESC:
                begin
                    if (sub_reg == 2'd0)
                    begin
                        if (fits)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = CHAR_PCT;
                            out_last_next  = 1'b0;
                            out_err_next   = 1'b0;
                            bw_next        = bw_reg + 16'(unit_len);
                            sub_next       = 2'd1;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                            done_unit   = 1'b1;
                        end
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hex_char(unit_byte[7:4]);
                        out_last_next  = 1'b0;
                        out_err_next   = 1'b0;
                        sub_next       = 2'd2;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hex_char(unit_byte[3:0]);
                        out_last_next  = 1'b0;
                        out_err_next   = 1'b0;
                        sub_next       = 2'd0;
                        done_unit      = 1'b1;
                    end
                end
                TAIL_BYTE:
                begin
                    if (fits)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = unit_byte;
                        out_last_next  = 1'b0;
                        out_err_next   = 1'b0;
                        bw_next        = bw_reg + 16'(unit_len);
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                    done_unit = 1'b1;
                end
                default:
                begin
                    done_unit = 1'b1;
                end
            endcase
            if (done_unit)
            begin
                if (last_unit)
                begin
                    pop       = 1'b1;
                    unit_next = '0;
                end
                else
                begin
                    unit_next = unit_reg + 3'd1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= '0;
            sub_reg       <= '0;
            bw_reg        <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unit_reg      <= unit_next;
            sub_reg       <= sub_next;
            bw_reg        <= bw_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

endmodule
